### design/brb_pkg.sv
// Package for the byte ring buffer: sizes, operation codes, state type and the
// structs passed between the bank lanes, the merge stage and the top level.
// No dependencies.
package brb_pkg;

    // Queue geometry (DEPTH and LANES are powers of two)
    localparam int DEPTH   = 1024;
    localparam int RESERVE = 1;
    localparam int LANES   = 8;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int ROWS    = DEPTH / LANES;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int LIDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W   = $clog2(LANES + 1);

    // Field widths
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 11;
    localparam int BYTES_W = 64;
    localparam int STAT_W  = 11;
    localparam int CMP_W   = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 80;
    localparam int OUT_USED_W = 1 + BYTES_W + 4 * STAT_W;
    localparam int OUT_DATA_W = 112;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT     = 3'd0,
        KIND_GET     = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_DISCARD = 3'd3,
        KIND_CLEAR   = 3'd4
    } t_kind;

    // Top-level sequencer states
    typedef enum logic {
        S_IDLE,
        S_MERGE
    } t_state;

    // Per-beat control broadcast to every bank lane
    typedef struct packed {
        logic [PTR_W-1:0] base;
        logic [CNT_W-1:0] cnt;
        logic             we;
        logic             re;
    } t_lane_ctl;

    // Control captured for the merge stage
    typedef struct packed {
        logic              acc;
        logic              rd;
        logic [LIDX_W-1:0] rot;
        logic [CNT_W-1:0]  cnt;
    } t_merge_ctl;

    // One result beat
    typedef struct packed {
        logic [STAT_W-1:0]  contig_write;
        logic [STAT_W-1:0]  contig_read;
        logic [STAT_W-1:0]  free_bytes;
        logic [STAT_W-1:0]  used_bytes;
        logic [BYTES_W-1:0] got_bytes;
        logic               accepted;
    } t_result;

endpackage

### design/byte_ring_buffer.sv
// Byte ring buffer top level: stream ports, pointer control, bank lanes and
// the result register. Depends on brb_pkg, brb_lane and brb_merge.
//
// For each input beat, in the cycle it is accepted the operation is checked
// against the pointers, the pointers move and up to LANES bank RAMs are
// written or read in parallel (one byte per bank); then, in the S_MERGE state,
// the registered bank read data is rotated into order and the result is loaded
// into the output register; S_MERGE waits while that register holds a result
// not yet taken. A new beat is accepted once the result has been loaded, and
// the output register holds a result while the next beat executes.
// The byte store needs no clearing after reset: only bytes that were put are
// ever read. A put writes bytes in order from the write position, a get or
// peek returns them from the read position, first byte lowest.
module byte_ring_buffer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input beat
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: count[10:0], put_bytes[74:11], zero pad[79:75]
    input  logic [brb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [brb_pkg::KIND_W-1:0]       s_axis_tuser,
    // Result beat
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: accepted[0], got_bytes[64:1], used_bytes[75:65], free_bytes[86:76],
    //        contig_read[97:87], contig_write[108:98], zero pad[111:109]
    output logic [brb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import brb_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  r_wp;
    t_merge_ctl        r_mctl;
    logic              r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    t_kind              kind;
    logic [COUNT_W-1:0] count;
    logic [BYTES_W-1:0] put_bytes;
    logic [CMP_W-1:0]   count_c;
    logic [CMP_W-1:0]   used_c;
    logic [CMP_W-1:0]   held_c;
    logic [CMP_W-1:0]   free_c;
    logic               nz;
    logic               lane_fit;
    logic               op_ok;
    logic [PTR_W-1:0]   rp_adv;
    logic [PTR_W-1:0]   wp_adv;
    logic               in_fire;
    logic               load;
    t_lane_ctl          lane_ctl;
    logic [LANES-1:0][7:0] lane_bytes;
    t_result            res;

    // Unpack the input beat
    assign kind      = t_kind'(s_axis_tuser);
    assign count     = s_axis_tdata[COUNT_W-1:0];
    assign put_bytes = s_axis_tdata[COUNT_W +: BYTES_W];
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // Check the operation against the space in use and free
    always_comb begin
        count_c  = CMP_W'(count);
        used_c   = CMP_W'(PTR_W'(r_wp - r_rp));
        held_c   = used_c + CMP_W'(RESERVE);
        free_c   = (held_c >= CMP_W'(DEPTH)) ? '0 : CMP_W'(DEPTH) - held_c;
        nz       = (count != '0);
        lane_fit = (count_c <= CMP_W'(LANES));
        rp_adv   = PTR_W'(CMP_W'(r_rp) + count_c);
        wp_adv   = PTR_W'(CMP_W'(r_wp) + count_c);
        case (kind)
            KIND_PUT:     op_ok = nz && lane_fit && (count_c <= free_c);
            KIND_GET,
            KIND_PEEK:    op_ok = nz && lane_fit && (count_c <= used_c);
            KIND_DISCARD: op_ok = nz && (count_c <= used_c);
            KIND_CLEAR:   op_ok = 1'b1;
            default:      op_ok = 1'b0;
        endcase
    end

    // Broadcast the bank access for this beat
    always_comb begin
        lane_ctl.base = (kind == KIND_PUT) ? r_wp : r_rp;
        lane_ctl.cnt  = CNT_W'(count);
        lane_ctl.we   = in_fire && op_ok && (kind == KIND_PUT);
        lane_ctl.re   = in_fire && op_ok && (kind == KIND_GET || kind == KIND_PEEK);
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        brb_lane u_lane (
            .i_clk       (i_clk),
            .i_lane_id   (LIDX_W'(g)),
            .i_ctl       (lane_ctl),
            .i_put_bytes (put_bytes),
            .o_rd_byte   (lane_bytes[g])
        );
    end

    brb_merge u_merge (
        .i_lane_bytes (lane_bytes),
        .i_ctl        (r_mctl),
        .i_rp         (r_rp),
        .i_wp         (r_wp),
        .o_res        (res)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, input ready and result load
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                load = !r_m_valid || m_axis_tready;
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance the pointers on an accepted operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
        end else if (in_fire && op_ok) begin
            case (kind)
                KIND_PUT: r_wp <= wp_adv;
                KIND_GET: begin
                    if (rp_adv == r_wp) begin
                        r_rp <= '0;
                        r_wp <= '0;
                    end else begin
                        r_rp <= rp_adv;
                    end
                end
                KIND_DISCARD: r_rp <= rp_adv;
                KIND_CLEAR: begin
                    r_rp <= '0;
                    r_wp <= '0;
                end
                default: ;
            endcase
        end
    end

    // Capture what the merge stage needs
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mctl.acc <= op_ok;
            r_mctl.rd  <= op_ok && (kind == KIND_GET || kind == KIND_PEEK);
            r_mctl.rot <= LIDX_W'(r_rp % LANES);
            r_mctl.cnt <= CNT_W'(count);
        end
    end

    // Result register: load from the merge stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {(OUT_DATA_W - OUT_USED_W)'(0), res.contig_write, res.contig_read,
                         res.free_bytes, res.used_bytes, res.got_bytes, res.accepted};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Fill level never eats into the reserve gap
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_wp - r_rp) <= PTR_W'(DEPTH - RESERVE))
        else $error("fill level exceeds depth minus reserve");

    // A get that empties the queue returns both pointers to zero
    a_get_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && op_ok && kind == KIND_GET && rp_adv == r_wp)
        |=> (r_rp == '0 && r_wp == '0))
        else $error("emptying get did not reset pointers");

    // An accepted beat goes to the merge cycle and blocks further input
    a_merge_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_MERGE && !s_axis_tready))
        else $error("accepted beat did not enter merge");

endmodule

### design/brb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/brb_lane.sv
// One bank lane: holds every LANES-th byte of the queue and works out which
// byte of the beat falls in its bank. Depends on brb_pkg and brb_ram.
module brb_lane (
    input  logic                      i_clk,
    input  logic [brb_pkg::LIDX_W-1:0] i_lane_id,
    input  brb_pkg::t_lane_ctl         i_ctl,
    input  logic [brb_pkg::BYTES_W-1:0] i_put_bytes,
    output logic [7:0]                 o_rd_byte
);
    import brb_pkg::*;

    logic [LIDX_W-1:0] base_lo;
    logic [LIDX_W:0]   off_raw;
    logic [LIDX_W-1:0] off;
    logic [PTR_W:0]    addr;
    logic [ROW_W-1:0]  row;
    logic              we;
    logic [7:0]        wdata;

    // Offset of this bank's byte within the beat
    always_comb begin
        base_lo = LIDX_W'(i_ctl.base % LANES);
        off_raw = {1'b0, i_lane_id} + (LIDX_W + 1)'(LANES) - {1'b0, base_lo};
        if (off_raw >= (LIDX_W + 1)'(LANES)) begin
            off_raw = off_raw - (LIDX_W + 1)'(LANES);
        end
        off = off_raw[LIDX_W-1:0];
    end

    // Row address, wrapping past the end of the queue
    always_comb begin
        addr  = {1'b0, i_ctl.base} + (PTR_W + 1)'(off);
        row   = ROW_W'(addr / LANES);
        we    = i_ctl.we && (CNT_W'(off) < i_ctl.cnt);
        wdata = i_put_bytes[{off, 3'b000} +: 8];
    end

    brb_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_re    (i_ctl.re),
        .i_addr  (row),
        .i_wdata (wdata),
        .o_rdata (o_rd_byte)
    );

endmodule

### design/brb_merge.sv
// Merge stage: rotates the bank read bytes into beat order, masks unused
// bytes and forms the status fields from the updated pointers.
// Depends on brb_pkg.
module brb_merge (
    input  logic [brb_pkg::LANES-1:0][7:0] i_lane_bytes,
    input  brb_pkg::t_merge_ctl            i_ctl,
    input  logic [brb_pkg::PTR_W-1:0]      i_rp,
    input  logic [brb_pkg::PTR_W-1:0]      i_wp,
    output brb_pkg::t_result               o_res
);
    import brb_pkg::*;

    logic [BYTES_W-1:0] got;
    logic [CMP_W-1:0]   rp_e;
    logic [CMP_W-1:0]   wp_e;
    logic [CMP_W-1:0]   used;
    logic [CMP_W-1:0]   held;
    logic [CMP_W-1:0]   free_v;
    logic [CMP_W-1:0]   cread;
    logic signed [CMP_W:0] rp_s;
    logic signed [CMP_W:0] wp_s;
    logic signed [CMP_W:0] cw_s;

    // Rotate lanes so that the byte at the read position lands lowest
    always_comb begin
        logic [LIDX_W:0] sel;
        got = '0;
        for (int i = 0; i < LANES; i++) begin
            sel = {1'b0, i_ctl.rot} + (LIDX_W + 1)'(i);
            if (sel >= (LIDX_W + 1)'(LANES)) begin
                sel = sel - (LIDX_W + 1)'(LANES);
            end
            if (i_ctl.rd && (CNT_W'(i) < i_ctl.cnt)) begin
                got[8*i +: 8] = i_lane_bytes[sel[LIDX_W-1:0]];
            end
        end
    end

    // Fill level, free space and contiguous runs
    always_comb begin
        rp_e  = CMP_W'(i_rp);
        wp_e  = CMP_W'(i_wp);
        used  = CMP_W'(PTR_W'(i_wp - i_rp));
        held  = used + CMP_W'(RESERVE);
        free_v = (held >= CMP_W'(DEPTH)) ? '0 : CMP_W'(DEPTH) - held;
        cread = (rp_e <= wp_e) ? wp_e - rp_e : CMP_W'(DEPTH) - rp_e;
        rp_s  = $signed({1'b0, rp_e});
        wp_s  = $signed({1'b0, wp_e});
        if (wp_e < rp_e) begin
            cw_s = rp_s - wp_s - (CMP_W + 1)'(RESERVE);
        end else if (rp_e < CMP_W'(RESERVE)) begin
            cw_s = (CMP_W + 1)'(DEPTH) - wp_s - (CMP_W + 1)'(RESERVE) + rp_s;
        end else begin
            cw_s = (CMP_W + 1)'(DEPTH) - wp_s;
        end
        if (cw_s < 0) begin
            cw_s = '0;
        end
    end

    assign o_res.accepted     = i_ctl.acc;
    assign o_res.got_bytes    = got;
    assign o_res.used_bytes   = STAT_W'(used);
    assign o_res.free_bytes   = STAT_W'(free_v);
    assign o_res.contig_read  = STAT_W'(cread);
    assign o_res.contig_write = STAT_W'($unsigned(cw_s));

endmodule
